FILE: hdl/mqsb_pkg.sv
// shared types and constants for the multi-queue shared buffer
package mqsb_pkg;

	localparam int OP_W   = 2;
	localparam int QN_W   = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	// input beat: operation, queue number, data word, padded to bytes
	localparam int IN_W  = ((OP_W + QN_W + DATA_W + 7) / 8) * 8;
	// output beat: head value, empty flag, status, padded to bytes
	localparam int OUT_W   = ((DATA_W + 1 + STAT_W + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - DATA_W - 1 - STAT_W;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY_POP = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LINK,
		S_UPDATE,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic link_rd;
		logic update;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} stat_t;

endpackage

FILE: hdl/mqsb_ram.sv
// generic single-port-write ram with registered read
module mqsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/mqsb_ctrl.sv
// sequencer for the reset sweep and one queue operation: lookup, link read, update, result
module mqsb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  mqsb_pkg::stat_t stat,
	output mqsb_pkg::cmd_t  cmd
);
	import mqsb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link_rd = 1'b1;
				state_d     = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

FILE: hdl/mqsb_datapath.sv
// queue tables, link and data stores, free list and output register
module mqsb_datapath #(
	parameter int NUM_ENTRIES = 256,
	parameter int NUM_QUEUES  = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mqsb_pkg::cmd_t              cmd,
	output mqsb_pkg::stat_t             stat,
	input  logic [mqsb_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mqsb_pkg::OUT_W-1:0]  m_tdata
);
	import mqsb_pkg::*;

	localparam int AW = $clog2(NUM_ENTRIES);
	localparam int PW = $clog2(NUM_ENTRIES + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [PW-1:0] NULL_P   = PW'(NUM_ENTRIES);
	localparam logic [QW-1:0] LAST_QUE = QW'(NUM_QUEUES - 1);

	logic [OP_W-1:0]   in_op;
	logic [QN_W-1:0]   in_qn;
	logic [DATA_W-1:0] in_word;

	logic [OP_W-1:0]   op_q;
	logic [QN_W-1:0]   qn_q;
	logic [DATA_W-1:0] word_q;

	logic [PW-1:0] free_head_q, mark_q, lnk_addr_q;
	logic [QW-1:0] clr_cnt_q;
	logic [STAT_W-1:0] status_q;
	logic nh_live_q, use_word_q;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [2*PW-1:0] qt_rdata, qt_wdata;
	logic [QW-1:0]   qt_waddr;
	logic            qt_we_eff;
	logic [PW-1:0]   lk_rdata;
	logic [AW-1:0]   lk_raddr;
	logic [DATA_W-1:0] dt_rdata;

	logic is_push, is_pop, q_ok, h_live, fh_live;
	logic [PW-1:0] h, t, link_val, nx, nh;
	logic [PW-1:0] fh_n, mark_n, qt_head_n, qt_tail_n, lk_wdata;
	logic [AW-1:0] lk_waddr;
	logic lk_we, dt_we, qt_we, use_word_n;
	logic [STAT_W-1:0] status_n;
	logic [DATA_W-1:0] head_val;

	assign in_op   = s_tdata[OP_W-1:0];
	assign in_qn   = s_tdata[OP_W +: QN_W];
	assign in_word = s_tdata[OP_W + QN_W +: DATA_W];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			qn_q   <= in_qn;
			word_q <= in_word;
		end
		if (cmd.link_rd) begin
			lnk_addr_q <= is_push ? free_head_q : h;
		end
		if (cmd.update) begin
			status_q   <= status_n;
			nh_live_q  <= nh < NULL_P;
			use_word_q <= use_word_n;
		end
		if (cmd.load) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, status_q, ~nh_live_q, head_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			mark_q      <= '0;
			clr_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + QW'(1);
			end
			if (cmd.update) begin
				free_head_q <= fh_n;
				mark_q      <= mark_n;
			end
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// head and tail of each queue, packed {tail, head}
	assign qt_we_eff = cmd.clear | (cmd.update & qt_we);
	assign qt_waddr  = cmd.clear ? clr_cnt_q : QW'(qn_q);
	assign qt_wdata  = cmd.clear ? {NULL_P, NULL_P} : {qt_tail_n, qt_head_n};

	mqsb_ram #(.WIDTH(2 * PW), .DEPTH(NUM_QUEUES)) u_qtab (
		.clk   (clk),
		.we    (qt_we_eff),
		.waddr (qt_waddr),
		.wdata (qt_wdata),
		.re    (cmd.capture),
		.raddr (QW'(in_qn)),
		.rdata (qt_rdata)
	);

	assign lk_raddr = is_push ? free_head_q[AW-1:0] : h[AW-1:0];

	mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_link (
		.clk   (clk),
		.we    (cmd.update & lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (cmd.link_rd),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	mqsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ENTRIES)) u_data (
		.clk   (clk),
		.we    (cmd.update & dt_we),
		.waddr (free_head_q[AW-1:0]),
		.wdata (word_q),
		.re    (cmd.update),
		.raddr (nh[AW-1:0]),
		.rdata (dt_rdata)
	);

	always_comb begin
		is_push = op_q == OP_PUSH;
		is_pop  = op_q == OP_POP;
		q_ok    = 32'(qn_q) < 32'(NUM_QUEUES);
		h       = qt_rdata[PW-1:0];
		t       = qt_rdata[2*PW-1:PW];
		h_live  = h < NULL_P;
		fh_live = free_head_q < NULL_P;
		// entries at or above the mark were never written and still chain to the next one
		link_val = (lnk_addr_q >= mark_q) ? lnk_addr_q + PW'(1) : lk_rdata;
		// the tail's link is stale, so a single-entry queue empties on pop
		nx = ((h == t) || !(link_val < NULL_P)) ? NULL_P : link_val;

		status_n   = ST_DONE;
		nh         = h;
		use_word_n = 1'b0;
		dt_we      = 1'b0;
		lk_we      = 1'b0;
		lk_waddr   = t[AW-1:0];
		lk_wdata   = free_head_q;
		qt_we      = 1'b0;
		qt_head_n  = h;
		qt_tail_n  = t;
		fh_n       = free_head_q;
		mark_n     = mark_q;

		if (!q_ok) begin
			nh = NULL_P;
			if (is_push) begin
				status_n = ST_FULL;
			end else if (is_pop) begin
				status_n = ST_EMPTY_POP;
			end
		end else if (is_push) begin
			if (!fh_live) begin
				status_n = ST_FULL;
			end else begin
				dt_we     = 1'b1;
				fh_n      = link_val;
				qt_we     = 1'b1;
				qt_tail_n = free_head_q;
				if (free_head_q == mark_q) begin
					mark_n = mark_q + PW'(1);
				end
				if (h_live) begin
					lk_we    = 1'b1;
					lk_waddr = t[AW-1:0];
					lk_wdata = free_head_q;
				end else begin
					qt_head_n  = free_head_q;
					nh         = free_head_q;
					use_word_n = 1'b1;
				end
			end
		end else if (is_pop) begin
			if (!h_live) begin
				status_n = ST_EMPTY_POP;
			end else begin
				lk_we     = 1'b1;
				lk_waddr  = h[AW-1:0];
				lk_wdata  = free_head_q;
				fh_n      = h;
				qt_we     = 1'b1;
				qt_head_n = nx;
				qt_tail_n = (nx < NULL_P) ? t : NULL_P;
				nh        = nx;
			end
		end
	end

	always_comb begin
		if (!nh_live_q) begin
			head_val = '0;
		end else if (use_word_q) begin
			head_val = word_q;
		end else begin
			head_val = dt_rdata;
		end
	end

	assign stat.clear_last = clr_cnt_q == LAST_QUE;
	assign stat.out_busy   = m_tvalid_q & ~m_tready;
	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = m_tdata_q;

endmodule

FILE: hdl/multi_queue_shared_buffer.sv
// top level: several fifo queues sharing one entry store with a linked free list
//
// Input beats on s_tvalid/s_tready/s_tdata carry an operation (push, pop, peek),
// a queue number and a data word. Each beat produces exactly one output beat on
// m_tvalid/m_tready/m_tdata with the addressed queue's head after the operation,
// an empty flag and a status (done, push rejected store full, pop on empty).
// One beat is processed at a time: the accept edge reads the head/tail table,
// the next cycle reads the link store, the next updates the stores and reads the
// new head's data, and the result is then loaded into the output register once
// the register is free. No new beat is accepted before that load.
// After reset the head/tail table is swept to empty, one queue per cycle, with
// s_tready low. The free list needs no sweep.
// When the receiver stalls the result waits in the output register; one more
// beat is accepted and worked on, then held until the register frees.
module multi_queue_shared_buffer #(
	parameter int NUM_ENTRIES = 256,
	parameter int NUM_QUEUES  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [mqsb_pkg::IN_W-1:0]  s_tdata,  // operation, queue_number, data_word, pad
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [mqsb_pkg::OUT_W-1:0] m_tdata   // head_value, queue_empty, status, pad
);
	import mqsb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mqsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mqsb_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.NUM_QUEUES  (NUM_QUEUES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: hdl/mqsb_checker.sv
// port-level checks for the multi-queue shared buffer, bound to the top level
module mqsb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mqsb_pkg::OUT_W-1:0] m_tdata
);
	import mqsb_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// an empty queue reports a zero head
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[DATA_W] |-> m_tdata[DATA_W-1:0] == '0)
		else $error("empty queue with nonzero head value");

	// a rejected pop always leaves the queue empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[DATA_W + 1 +: STAT_W] == ST_EMPTY_POP |-> m_tdata[DATA_W])
		else $error("pop on empty reported a nonempty queue");

	// one beat in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
